FILE: hw/rtl/kqm_pkg.sv
// Shared types and codes for the keyed queue with move-to-front.
`timescale 1ns / 1ps
`default_nettype none

package kqm_pkg;

    // One stored record, as it sits in a memory word.
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  age;
        logic [63:0] name;
        logic [63:0] cond;
    } t_rec;

    // Access controls from the sequencer to the record store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_POP    = 3'd1;
    localparam logic [2:0] FN_MOVE   = 3'd2;
    localparam logic [2:0] FN_SEARCH = 3'd3;
    localparam logic [2:0] FN_UPDATE = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/keyed_queue_move_to_front_unit.sv
// Top level: sequencer for the keyed record queue with move-to-front.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------------
//  request   | i_start / o_busy   | i_func, i_record_id, i_record_age, i_record_name,
//            |                    | i_record_condition
//  result    | o_done (strobe)    | o_status, o_found_id, o_found_age, o_found_name,
//            |                    | o_found_condition
//
// A request is taken on a clock edge where i_start is high and o_busy is low.
// Append, and any request that needs no lookup (empty queue, unused code),
// finishes without a walk: o_done rises the next cycle and o_busy stays low.
// Pop, search and update walk the queue from the head, one memory read per
// cycle. Move to front adds a second walk back over the entries ahead of the
// match. The single read port of the record store is what paces the walks.
// The receiver cannot stall, so every result is shown for exactly one cycle.
// Reset is synchronous and active low; it empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module keyed_queue_move_to_front_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [2:0]  i_func,
    input  wire  [15:0] i_record_id,
    input  wire  [7:0]  i_record_age,
    input  wire  [63:0] i_record_name,
    input  wire  [63:0] i_record_condition,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_found_id,
    output logic [7:0]  o_found_age,
    output logic [63:0] o_found_name,
    output logic [63:0] o_found_condition
);

    // Position width indexes a slot; count width also holds the full depth.
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] HEAD_TOP = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,  // waiting for a request
        S_SCAN  = 4'b0010,  // walking from the head, comparing keys
        S_MOVE  = 4'b0100,  // shifting the entries ahead of the match back by one
        S_FRONT = 4'b1000   // placing the moved record at the head
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head,  n_head;
    logic [CW-1:0]   r_idx,   n_idx;     // next position to read
    logic [AW-1:0]   r_cidx,  n_cidx;    // position of the word now in the read register
    logic            r_pend,  n_pend;    // read register holds a word to look at
    logic            r_done,  n_done;
    logic [1:0]      r_status, n_status;
    kqm_pkg::t_rec   r_out,   n_out;
    kqm_pkg::t_rec   r_rec,   n_rec;     // record caught by the walk
    logic [2:0]      r_func,  n_func;
    logic [15:0]     r_key,   n_key;
    logic [7:0]      r_age,   n_age;
    logic [63:0]     r_name,  n_name;
    logic [63:0]     r_cond,  n_cond;

    kqm_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     mem_rd_idx;
    logic [AW-1:0]     mem_wr_idx;
    kqm_pkg::t_rec     mem_wr_data;
    kqm_pkg::t_rec     mem_rd_data;
    kqm_pkg::t_rec     upd_rec;
    logic              rd_hit;

    kqm_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_head    (r_head),
        .i_rd_idx  (mem_rd_idx),
        .i_wr_idx  (mem_wr_idx),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    // The one key comparator: a pop takes the head word without a compare.
    assign rd_hit = r_pend && ((r_func == kqm_pkg::FN_POP) || (mem_rd_data.id == r_key));

    // An update keeps the stored id and takes everything else from the request.
    always_comb begin
        upd_rec      = mem_rd_data;
        upd_rec.age  = r_age;
        upd_rec.name = r_name;
        upd_rec.cond = r_cond;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_idx    = r_idx;
        n_cidx   = r_cidx;
        n_pend   = r_pend;
        n_done   = 1'b0;
        n_status = r_status;
        n_out    = r_out;
        n_rec    = r_rec;
        n_func   = r_func;
        n_key    = r_key;
        n_age    = r_age;
        n_name   = r_name;
        n_cond   = r_cond;

        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_rd_idx    = r_idx[AW-1:0];
        mem_wr_idx    = '0;
        mem_wr_data   = r_rec;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func   = i_func;
                    n_key    = i_record_id;
                    n_age    = i_record_age;
                    n_name   = i_record_name;
                    n_cond   = i_record_condition;
                    n_status = kqm_pkg::ST_MISS;
                    n_out    = '0;
                    n_pend   = 1'b0;
                    n_idx    = '0;
                    case (i_func) inside
                        kqm_pkg::FN_APPEND: begin
                            n_done = 1'b1;
                            if (r_count == DEPTH_C) begin
                                n_status = kqm_pkg::ST_FULL;
                            end else begin
                                mem_ctl.wr_en    = 1'b1;
                                mem_wr_idx       = r_count[AW-1:0];
                                mem_wr_data.id   = i_record_id;
                                mem_wr_data.age  = i_record_age;
                                mem_wr_data.name = i_record_name;
                                mem_wr_data.cond = i_record_condition;
                                n_count          = r_count + 1'b1;
                                n_status         = kqm_pkg::ST_OK;
                            end
                        end
                        kqm_pkg::FN_POP, kqm_pkg::FN_MOVE,
                        kqm_pkg::FN_SEARCH, kqm_pkg::FN_UPDATE: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (rd_hit) begin
                    n_rec  = mem_rd_data;
                    n_pend = 1'b0;
                    case (r_func)
                        kqm_pkg::FN_POP: begin
                            n_head   = (r_head == HEAD_TOP) ? '0 : r_head + 1'b1;
                            n_count  = r_count - 1'b1;
                            n_done   = 1'b1;
                            n_status = kqm_pkg::ST_OK;
                            n_out    = mem_rd_data;
                            n_state  = S_IDLE;
                        end
                        kqm_pkg::FN_MOVE: begin
                            if (r_cidx == '0) begin
                                n_done   = 1'b1;
                                n_status = kqm_pkg::ST_OK;
                                n_out    = mem_rd_data;
                                n_state  = S_IDLE;
                            end else begin
                                n_idx   = CW'(r_cidx) - 1'b1;
                                n_state = S_MOVE;
                            end
                        end
                        kqm_pkg::FN_UPDATE: begin
                            mem_ctl.wr_en = 1'b1;
                            mem_wr_idx    = r_cidx;
                            mem_wr_data   = upd_rec;
                            n_done        = 1'b1;
                            n_status      = kqm_pkg::ST_OK;
                            n_out         = upd_rec;
                            n_state       = S_IDLE;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = kqm_pkg::ST_OK;
                            n_out    = mem_rd_data;
                            n_state  = S_IDLE;
                        end
                    endcase
                end else if (r_pend && (r_idx == r_count)) begin
                    // The tail was compared without a match.
                    n_done  = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    n_cidx        = r_idx[AW-1:0];
                    n_pend        = 1'b1;
                    n_idx         = r_idx + 1'b1;
                end
            end

            S_MOVE: begin
                // Each word read in the cycle before lands one position further from the head.
                if (r_pend) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_wr_idx    = r_cidx + 1'b1;
                    mem_wr_data   = mem_rd_data;
                end
                if (r_pend && (r_cidx == '0)) begin
                    n_pend  = 1'b0;
                    n_state = S_FRONT;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    n_cidx        = r_idx[AW-1:0];
                    n_pend        = 1'b1;
                    n_idx         = r_idx - 1'b1;
                end
            end

            S_FRONT: begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_idx    = '0;
                mem_wr_data   = r_rec;
                n_done        = 1'b1;
                n_status      = kqm_pkg::ST_OK;
                n_out         = r_rec;
                n_state       = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cidx   <= n_cidx;
        r_status <= n_status;
        r_out    <= n_out;
        r_rec    <= n_rec;
        r_func   <= n_func;
        r_key    <= n_key;
        r_age    <= n_age;
        r_name   <= n_name;
        r_cond   <= n_cond;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_found_id        = r_out.id;
    assign o_found_age       = r_out.age;
    assign o_found_name      = r_out.name;
    assign o_found_condition = r_out.cond;

    // The count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above queue depth");

    // A walk only runs over a queue that holds something.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("walk started on an empty queue");

    // A full status is only reported while the queue is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == kqm_pkg::ST_FULL)) |-> (r_count == DEPTH_C))
        else $error("full status with free slots");

    // Failed requests carry no record.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != kqm_pkg::ST_OK)) |->
            ((o_found_id == '0) && (o_found_age == '0) &&
             (o_found_name == '0) && (o_found_condition == '0)))
        else $error("failed request returned record data");

    // A successful pop leaves one record fewer.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == kqm_pkg::ST_OK) && (r_func == kqm_pkg::FN_POP)
            && $past(r_state == S_SCAN)) |-> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not shrink the queue");

endmodule

`default_nettype wire

FILE: hw/rtl/kqm_mem.sv
// Circular record store: maps queue positions onto memory slots from the head pointer.
`timescale 1ns / 1ps
`default_nettype none

module kqm_mem #(
    parameter int DEPTH = 32
) (
    input  wire                        i_clk,
    input  kqm_pkg::t_mem_ctl          i_ctl,
    input  wire [$clog2(DEPTH)-1:0]    i_head,
    input  wire [$clog2(DEPTH)-1:0]    i_rd_idx,
    input  wire [$clog2(DEPTH)-1:0]    i_wr_idx,
    input  kqm_pkg::t_rec              i_wr_data,
    output kqm_pkg::t_rec              o_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    kqm_pkg::t_rec r_mem [DEPTH];
    kqm_pkg::t_rec r_rd_data;

    logic [AW:0]   rd_sum;
    logic [AW:0]   wr_sum;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // Head plus position stays below twice the depth, so one subtract wraps it.
    always_comb begin
        rd_sum = {1'b0, i_head} + {1'b0, i_rd_idx};
        wr_sum = {1'b0, i_head} + {1'b0, i_wr_idx};
        if (rd_sum >= DEPTH_W) begin
            rd_sum = rd_sum - DEPTH_W;
        end
        if (wr_sum >= DEPTH_W) begin
            wr_sum = wr_sum - DEPTH_W;
        end
        rd_addr = rd_sum[AW-1:0];
        wr_addr = wr_sum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: dv/tb_keyed_queue_move_to_front_unit.sv
// Testbench for the keyed record queue with move-to-front.
`timescale 1ns / 1ps

module tb_keyed_queue_move_to_front_unit;

    localparam int QUEUE_DEPTH = 32;
    // The longest request is a move to front of the tail entry.
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 16;
    localparam int CYCLE_LIMIT = 1_000_000;

    // The block defines no behavior for these codes beyond a miss status.
    localparam logic [2:0] FN_FIRST_SPARE = 3'd5;
    localparam logic [2:0] FN_LAST_SPARE  = 3'd7;

    typedef struct packed {
        logic [1:0]    status;
        kqm_pkg::t_rec rec;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_func = kqm_pkg::FN_APPEND;
    logic [15:0] i_record_id = '0;
    logic [7:0]  i_record_age = '0;
    logic [63:0] i_record_name = '0;
    logic [63:0] i_record_condition = '0;
    logic        o_busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [15:0] o_found_id;
    logic [7:0]  o_found_age;
    logic [63:0] o_found_name;
    logic [63:0] o_found_condition;

    keyed_queue_move_to_front_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_func            (i_func),
        .i_record_id       (i_record_id),
        .i_record_age      (i_record_age),
        .i_record_name     (i_record_name),
        .i_record_condition(i_record_condition),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_found_id        (o_found_id),
        .o_found_age       (o_found_age),
        .o_found_name      (o_found_name),
        .o_found_condition (o_found_condition)
    );

    // Shadow copy of the queue contents. Slot 0 is the head.
    kqm_pkg::t_rec queue_recs[QUEUE_DEPTH];
    int            queue_count = 0;
    t_result       pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            sender_idle_pct = 0;
    logic [15:0]   key_pool[16];

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs with requests outstanding.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", field, got, want));
        end
    endtask

    // Applies one request to the shadow queue and returns the result it must produce.
    // Lookups always take the first match from the head, so duplicate ids resolve there.
    function automatic t_result predict_queue_op(input logic [2:0] fn,
                                                 input kqm_pkg::t_rec req);
        t_result       res;
        kqm_pkg::t_rec moved;
        int            hit;
        res = '0;
        res.status = kqm_pkg::ST_MISS;
        hit = queue_count;
        for (int i = queue_count - 1; i >= 0; i--) begin
            if (queue_recs[i].id == req.id) hit = i;
        end
        case (fn)
            kqm_pkg::FN_APPEND: begin
                if (queue_count >= QUEUE_DEPTH) begin
                    res.status = kqm_pkg::ST_FULL;
                end else begin
                    queue_recs[queue_count] = req;
                    queue_count++;
                    res.status = kqm_pkg::ST_OK;
                end
            end
            kqm_pkg::FN_POP: begin
                if (queue_count > 0) begin
                    res.status = kqm_pkg::ST_OK;
                    res.rec = queue_recs[0];
                    for (int i = 1; i < queue_count; i++) queue_recs[i - 1] = queue_recs[i];
                    queue_count--;
                end
            end
            kqm_pkg::FN_MOVE: begin
                if (hit < queue_count) begin
                    moved = queue_recs[hit];
                    for (int i = hit; i > 0; i--) queue_recs[i] = queue_recs[i - 1];
                    queue_recs[0] = moved;
                    res.status = kqm_pkg::ST_OK;
                    res.rec = moved;
                end
            end
            kqm_pkg::FN_SEARCH: begin
                if (hit < queue_count) begin
                    res.status = kqm_pkg::ST_OK;
                    res.rec = queue_recs[hit];
                end
            end
            kqm_pkg::FN_UPDATE: begin
                if (hit < queue_count) begin
                    queue_recs[hit].age = req.age;
                    queue_recs[hit].name = req.name;
                    queue_recs[hit].cond = req.cond;
                    res.status = kqm_pkg::ST_OK;
                    res.rec = queue_recs[hit];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Every strobed result is matched against the oldest outstanding prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result strobed with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(o_status), 64'(want.status));
                check_field("found_id", 64'(o_found_id), 64'(want.rec.id));
                check_field("found_age", 64'(o_found_age), 64'(want.rec.age));
                check_field("found_name", o_found_name, want.rec.name);
                check_field("found_condition", o_found_condition, want.rec.cond);
            end
        end
    end

    // Presents one request, holds it until taken, then maybe idles the request side.
    // Must be called just after a rising edge.
    task automatic send_request(input logic [2:0] fn, input kqm_pkg::t_rec req);
        i_start <= 1'b1;
        i_func <= fn;
        i_record_id <= req.id;
        i_record_age <= req.age;
        i_record_name <= req.name;
        i_record_condition <= req.cond;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_results.push_back(predict_queue_op(fn, req));
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic kqm_pkg::t_rec make_rec(input logic [15:0] id, input logic [7:0] age,
                                               input logic [63:0] name,
                                               input logic [63:0] cond);
        kqm_pkg::t_rec r;
        r.id = id;
        r.age = age;
        r.name = name;
        r.cond = cond;
        return r;
    endfunction

    // Mostly keys from a small pool so that lookups hit and ids repeat.
    function automatic kqm_pkg::t_rec random_rec();
        logic [15:0] id;
        if ($urandom_range(0, 9) == 0) id = 16'($urandom_range(0, 65535));
        else id = key_pool[4'($urandom_range(0, 15))];
        return make_rec(id, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                        {$urandom, $urandom});
    endfunction

    task automatic refresh_key_pool();
        foreach (key_pool[k]) key_pool[k] = 16'($urandom_range(0, 65535));
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
    endtask

    task automatic drain_queue();
        while (queue_count > 0) send_request(kqm_pkg::FN_POP, random_rec());
    endtask

    // Every lookup on an empty queue misses, and so do the spare codes.
    task automatic test_empty_queue();
        send_request(kqm_pkg::FN_POP, make_rec(16'h0000, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_MOVE, make_rec(16'hFFFF, 8'hFF, '1, '1));
        send_request(kqm_pkg::FN_SEARCH, make_rec(16'h0000, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_UPDATE, make_rec(16'hFFFF, 8'hFF, '1, '1));
        for (int f = FN_FIRST_SPARE; f <= FN_LAST_SPARE; f++) begin
            send_request(3'(f), make_rec(16'h0000, 8'h00, '0, '0));
        end
    endtask

    // Records at the field extremes go in and come back out unchanged.
    task automatic test_record_extremes();
        send_request(kqm_pkg::FN_APPEND, make_rec(16'h0000, 8'h00, 64'h0, 64'h0));
        send_request(kqm_pkg::FN_APPEND, make_rec(16'hFFFF, 8'hFF, '1, '1));
        send_request(kqm_pkg::FN_APPEND, make_rec(16'h1234, 8'h5A, 64'hA5A5_A5A5_A5A5_A5A5,
                                                  64'h5A5A_5A5A_5A5A_5A5A));
        send_request(kqm_pkg::FN_SEARCH, make_rec(16'hFFFF, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_SEARCH, make_rec(16'h0000, 8'hFF, '1, '1));
        send_request(kqm_pkg::FN_SEARCH, make_rec(16'h7777, 8'h00, '0, '0));
    endtask

    // Duplicate ids, move of a middle entry and of the head, update, misses, pops.
    task automatic test_lookup_ops();
        send_request(kqm_pkg::FN_APPEND, make_rec(16'hFFFF, 8'h11, 64'h0123_4567_89AB_CDEF,
                                                  64'hFEDC_BA98_7654_3210));
        send_request(kqm_pkg::FN_SEARCH, make_rec(16'hFFFF, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_MOVE, make_rec(16'hFFFF, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_MOVE, make_rec(16'hFFFF, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_MOVE, make_rec(16'h1234, 8'h00, '0, '0));
        send_request(kqm_pkg::FN_UPDATE, make_rec(16'h1234, 8'hC3, 64'hDEAD_BEEF_0000_FFFF,
                                                  64'h8000_0000_0000_0001));
        send_request(kqm_pkg::FN_UPDATE, make_rec(16'h7777, 8'h01, '1, '1));
        send_request(kqm_pkg::FN_MOVE, make_rec(16'h7777, 8'h00, '0, '0));
        send_request(FN_LAST_SPARE, make_rec(16'h1234, 8'h00, '0, '0));
        drain_queue();
        send_request(kqm_pkg::FN_POP, make_rec(16'h0000, 8'h00, '0, '0));
    endtask

    // Random requests; append_pct steers whether the queue tends to grow or shrink.
    task automatic test_random_mix(input int n_items, input int idle_pct, input int append_pct);
        logic [2:0] fn;
        int         pick;
        sender_idle_pct = idle_pct;
        refresh_key_pool();
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < append_pct) begin
                fn = kqm_pkg::FN_APPEND;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) fn = kqm_pkg::FN_POP;
                else if (pick < 45) fn = kqm_pkg::FN_MOVE;
                else if (pick < 65) fn = kqm_pkg::FN_SEARCH;
                else if (pick < 90) fn = kqm_pkg::FN_UPDATE;
                else fn = 3'($urandom_range(FN_FIRST_SPARE, FN_LAST_SPARE));
            end
            send_request(fn, random_rec());
        end
    endtask

    // Fills the queue, hits the full status, works on a full queue, then empties it.
    task automatic test_fill_and_drain(input int idle_pct);
        sender_idle_pct = idle_pct;
        refresh_key_pool();
        while (queue_count < QUEUE_DEPTH) send_request(kqm_pkg::FN_APPEND, random_rec());
        repeat (3) send_request(kqm_pkg::FN_APPEND, random_rec());
        // Move of the tail entry is the longest walk the block makes.
        send_request(kqm_pkg::FN_MOVE, queue_recs[QUEUE_DEPTH - 1]);
        send_request(kqm_pkg::FN_SEARCH, queue_recs[QUEUE_DEPTH - 1]);
        test_random_mix(40, idle_pct, 60);
        drain_queue();
        send_request(kqm_pkg::FN_POP, random_rec());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_record_extremes();
        test_lookup_ops();
        test_random_mix(600, 0, 35);
        test_fill_and_drain(82);
        test_random_mix(600, 82, 30);
        test_fill_and_drain(0);
        test_random_mix(600, 8, 35);

        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
